// ===== src/ascii_panel_command_line_parser_unit_assert.svh =====
// Assertion macros shared by the command line parser modules.
`ifndef ASCII_PANEL_COMMAND_LINE_PARSER_UNIT_ASSERT_SVH
`define ASCII_PANEL_COMMAND_LINE_PARSER_UNIT_ASSERT_SVH

// Implication checked in the same cycle, disabled while reset is applied.
`define APCLP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Implication checked in the next cycle, disabled while reset is applied.
`define APCLP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== src/apclp_pkg.sv =====
// Shared types and constants of the ASCII panel command line parser.
`timescale 1ns / 1ps

package apclp_pkg;

    // Default line buffer length, terminator included.
    localparam int LINE_BUFFER_LEN_DEF = 64;

    // Special characters.
    localparam logic [7:0] CHAR_LF = 8'h0a;
    localparam logic [7:0] CHAR_CR = 8'h0d;

    // Message kinds.
    localparam logic [3:0] KIND_NONE       = 4'd0;
    localparam logic [3:0] KIND_HELLO      = 4'd1;
    localparam logic [3:0] KIND_STAT_BEGIN = 4'd2;
    localparam logic [3:0] KIND_STAT_END   = 4'd3;
    localparam logic [3:0] KIND_SW_ON      = 4'd4;
    localparam logic [3:0] KIND_SW_OFF     = 4'd5;
    localparam logic [3:0] KIND_LED_ON     = 4'd6;
    localparam logic [3:0] KIND_LED_OFF    = 4'd7;
    localparam logic [3:0] KIND_LOG_LEVEL  = 4'd8;
    localparam logic [3:0] KIND_REPORT_EN  = 4'd9;

    // One classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic            line_end;
        logic            dropped;
        logic            len_is_four;
        logic [3:0][7:0] head;
    } apclp_entry_t;

endpackage

// ===== src/apclp_front.sv =====
// Front end: accepts bytes, tracks the line and classifies each request.
`timescale 1ns / 1ps

module apclp_front import apclp_pkg::*; #(
    parameter int LINE_BUFFER_LEN = LINE_BUFFER_LEN_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_rx_byte,
    input  logic         q_ready,
    output logic         q_push,
    output apclp_entry_t q_entry
);

    localparam int LEN_W = $clog2(LINE_BUFFER_LEN);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(LINE_BUFFER_LEN - 1);
    localparam logic [LEN_W-1:0] HEAD_LEN = LEN_W'(4);

    logic [LEN_W-1:0] len_reg, len_next;
    logic [3:0][7:0]  head_reg;
    logic             is_end;
    logic             is_full;
    logic             accept;

    // Classify the incoming byte against the current line state.
    assign is_end  = (s_rx_byte == CHAR_LF) || (s_rx_byte == CHAR_CR);
    assign is_full = (len_reg == LEN_MAX);
    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign q_push  = accept;

    always_comb begin
        q_entry.line_end    = is_end;
        q_entry.dropped     = !is_end && is_full;
        q_entry.len_is_four = (len_reg == HEAD_LEN);
        q_entry.head        = head_reg;
    end

    // Line length: cleared by a terminator, held when the buffer is full.
    always_comb begin
        len_next = len_reg;
        if (accept) begin
            if (is_end) begin
                len_next = '0;
            end else if (!is_full) begin
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

    // The first four characters of the line are kept for decoding.
    always_ff @(posedge aclk) begin
        if (accept && !is_end && !is_full && (len_reg < HEAD_LEN)) begin
            head_reg[len_reg[1:0]] <= s_rx_byte;
        end
    end

endmodule

// ===== src/apclp_queue.sv =====
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps

`include "ascii_panel_command_line_parser_unit_assert.svh"

module apclp_queue import apclp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  apclp_entry_t push_entry,
    output logic         push_ready,
    input  logic         pop,
    output logic         pop_valid,
    output apclp_entry_t pop_entry
);

    apclp_entry_t [1:0] slot_reg;
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `APCLP_ASSERT_SAME(a_no_push_full, aclk, aresetn, push, count_reg != 2'd2)
    `APCLP_ASSERT_SAME(a_no_pop_empty, aclk, aresetn, pop, count_reg != 2'd0)
    `APCLP_ASSERT_NEXT(a_fill_counts, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 2'd1)

endmodule

// ===== src/apclp_back.sv =====
// Back end: decodes finished lines and holds the result register.
`timescale 1ns / 1ps

`include "ascii_panel_command_line_parser_unit_assert.svh"

module apclp_back import apclp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    input  apclp_entry_t q_entry,
    output logic         q_pop,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_line_done,
    output logic [3:0]   m_msg_kind,
    output logic [3:0]   m_component,
    output logic [3:0]   m_arg_value,
    output logic         m_byte_dropped
);

    logic       valid_reg, valid_next;
    logic       done_reg;
    logic [3:0] kind_reg;
    logic [3:0] comp_reg;
    logic [3:0] arg_reg;
    logic       dropped_reg;
    logic [3:0] kind_d;
    logic [3:0] comp_d;
    logic [3:0] arg_d;
    logic       load;

    // Decode the four kept characters into a message.
    always_comb begin
        logic [7:0] c0, c1, c2, c3;
        logic       dig2, dig3, bit3;
        c0 = q_entry.head[0];
        c1 = q_entry.head[1];
        c2 = q_entry.head[2];
        c3 = q_entry.head[3];
        dig2 = (c2 >= "0") && (c2 <= "9");
        dig3 = (c3 >= "0") && (c3 <= "9");
        bit3 = (c3 == "0") || (c3 == "1");
        kind_d = KIND_NONE;
        comp_d = 4'd0;
        arg_d  = 4'd0;
        if (q_entry.line_end && q_entry.len_is_four) begin
            priority if (c0 == "h" && c1 == "e" && c2 == "l" && c3 == "o") begin
                kind_d = KIND_HELLO;
            end else if (c0 == "s" && c1 == "w" && dig2 && bit3) begin
                kind_d = (c3 == "0") ? KIND_SW_OFF : KIND_SW_ON;
                comp_d = c2[3:0];
            end else if (c0 == "l" && c1 == "d" && dig2 && bit3) begin
                kind_d = (c3 == "0") ? KIND_LED_OFF : KIND_LED_ON;
                comp_d = c2[3:0];
            end else if (c0 == "l" && c1 == "v" && c2 == "l" && dig3) begin
                kind_d = KIND_LOG_LEVEL;
                arg_d  = c3[3:0];
            end else if (c0 == "s" && c1 == "r" && c2 == "e" && dig3) begin
                kind_d = KIND_REPORT_EN;
                arg_d  = c3[3:0];
            end else if (c0 == "s" && c1 == "t" && c2 == "a" && c3 == "t") begin
                kind_d = KIND_STAT_BEGIN;
            end else if (c0 == "s" && c1 == "e" && c2 == "n" && c3 == "d") begin
                kind_d = KIND_STAT_END;
            end else begin
                kind_d = KIND_NONE;
            end
        end
    end

    // The result register takes a new request when it is empty or being drained.
    assign load       = q_valid && (!valid_reg || m_ready);
    assign q_pop      = load;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            done_reg    <= q_entry.line_end;
            kind_reg    <= kind_d;
            comp_reg    <= comp_d;
            arg_reg     <= arg_d;
            dropped_reg <= q_entry.dropped;
        end
    end

    assign m_valid        = valid_reg;
    assign m_line_done    = done_reg;
    assign m_msg_kind     = kind_reg;
    assign m_component    = comp_reg;
    assign m_arg_value    = arg_reg;
    assign m_byte_dropped = dropped_reg;

    `APCLP_ASSERT_SAME(a_plain_byte_empty, aclk, aresetn, valid_reg && !done_reg, kind_reg == KIND_NONE && comp_reg == 4'd0 && arg_reg == 4'd0)
    `APCLP_ASSERT_SAME(a_end_not_dropped, aclk, aresetn, valid_reg && done_reg, !dropped_reg)
    `APCLP_ASSERT_SAME(a_comp_kinds, aclk, aresetn, valid_reg && comp_reg != 4'd0, kind_reg == KIND_SW_ON || kind_reg == KIND_SW_OFF || kind_reg == KIND_LED_ON || kind_reg == KIND_LED_OFF)

endmodule

// ===== src/ascii_panel_command_line_parser_unit.sv =====
// Top level of the ASCII panel command line parser.
`timescale 1ns / 1ps

// The parser takes one received byte per cycle while the queue has room and
// returns exactly one result per byte, in order. A line feed or carriage return
// ends a line; a line of exactly four characters is decoded into a message
// (hello, status begin/end, switch or LED on/off with its digit, log level or
// report enable with its digit), anything else gives kind none. Bytes beyond
// LINE_BUFFER_LEN-1 characters are dropped and flagged. Sustained rate is one
// byte per clock while the result channel takes results; a result passes
// through the two-entry queue and then the output register, and the input
// keeps flowing until three results wait for the result channel to take them.

module ascii_panel_command_line_parser_unit import apclp_pkg::*; #(
    parameter int LINE_BUFFER_LEN = LINE_BUFFER_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_line_done,
    output logic [3:0] m_msg_kind,
    output logic [3:0] m_component,
    output logic [3:0] m_arg_value,
    output logic       m_byte_dropped
);

    logic         q_push;
    logic         q_push_ready;
    apclp_entry_t q_push_entry;
    logic         q_pop;
    logic         q_pop_valid;
    apclp_entry_t q_pop_entry;

    // Front end: line tracking and classification.
    apclp_front #(
        .LINE_BUFFER_LEN(LINE_BUFFER_LEN)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_rx_byte(s_rx_byte),
        .q_ready  (q_push_ready),
        .q_push   (q_push),
        .q_entry  (q_push_entry)
    );

    // Decoupling queue.
    apclp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(q_push_entry),
        .push_ready(q_push_ready),
        .pop       (q_pop),
        .pop_valid (q_pop_valid),
        .pop_entry (q_pop_entry)
    );

    // Back end: decode and result register.
    apclp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_pop_valid),
        .q_entry       (q_pop_entry),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_done   (m_line_done),
        .m_msg_kind    (m_msg_kind),
        .m_component   (m_component),
        .m_arg_value   (m_arg_value),
        .m_byte_dropped(m_byte_dropped)
    );

endmodule
